@@ design/bcdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdf_pkg
// Shared types, codes and helpers for the BCD digit display formatter.
// ----------------------------------------------------------------------------
package bcdf_pkg;

  typedef enum logic [1:0] {
    OP_NUMBER = 2'd0,
    OP_LO     = 2'd1,
    OP_HI     = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam logic [3:0]  CODE_BLANK = 4'hF;
  localparam logic [3:0]  CODE_L     = 4'd13;
  localparam logic [3:0]  CODE_H     = 4'd12;
  localparam logic [13:0] VALUE_MAX  = 14'd9999;
  localparam logic [13:0] UNIT_THOU  = 14'd1000;
  localparam logic [13:0] UNIT_HUND  = 14'd100;
  localparam logic [13:0] UNIT_TENS  = 14'd10;

  typedef struct packed {
    op_e         opcode;
    logic        group_select;
    logic [13:0] number_value;
    logic [3:0]  point_bits;
  } cmd_t;

  typedef struct packed {
    logic [3:0] digit_register;
    logic [7:0] digit_code;
    logic       last_write;
  } res_t;

  typedef struct packed {
    op_e        opcode;
    logic       group_select;
    logic [3:0] point_bits;
    logic [3:0] d_thou;
    logic [3:0] d_hund;
    logic [3:0] d_tens;
    logic [3:0] d_unit;
  } digits_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rest;
  } split_t;

  // v < 10 * unit; one decimal digit by parallel compares against k * unit
  function automatic split_t split_digit(input logic [13:0] v, input logic [13:0] unit);
    split_t      s;
    logic [13:0] step;
    s.digit = 4'd0;
    s.rest  = v;
    step    = 14'd0;
    for (int k = 1; k < 10; k++) begin
      step = step + unit;
      if (v >= step) begin
        s.digit = 4'(k);
        s.rest  = v - step;
      end
    end
    return s;
  endfunction

endpackage

@@ design/bcdf_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdf_convert
// Four-stage binary to BCD pipeline with per-stage valid bits and stall.
// ----------------------------------------------------------------------------
module bcdf_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bcdf_pkg::cmd_t    cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bcdf_pkg::digits_t out_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  bcdf_pkg::cmd_t    s1_cmd_q;
  bcdf_pkg::cmd_t    s2_cmd_q;
  logic [3:0]        s2_thou_q;
  logic [9:0]        s2_rest_q;
  bcdf_pkg::cmd_t    s3_cmd_q;
  logic [3:0]        s3_thou_q;
  logic [3:0]        s3_hund_q;
  logic [6:0]        s3_rest_q;
  bcdf_pkg::digits_t s4_q;

  logic [13:0]       sat;
  bcdf_pkg::split_t  sp_thou, sp_hund, sp_tens;
  bcdf_pkg::digits_t s4_d;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    sat = (s1_cmd_q.number_value > bcdf_pkg::VALUE_MAX) ? bcdf_pkg::VALUE_MAX
                                                        : s1_cmd_q.number_value;
    sp_thou = bcdf_pkg::split_digit(sat, bcdf_pkg::UNIT_THOU);
    sp_hund = bcdf_pkg::split_digit({4'd0, s2_rest_q}, bcdf_pkg::UNIT_HUND);
    sp_tens = bcdf_pkg::split_digit({7'd0, s3_rest_q}, bcdf_pkg::UNIT_TENS);
    s4_d.opcode       = s3_cmd_q.opcode;
    s4_d.group_select = s3_cmd_q.group_select;
    s4_d.point_bits   = s3_cmd_q.point_bits;
    s4_d.d_thou       = s3_thou_q;
    s4_d.d_hund       = s3_hund_q;
    s4_d.d_tens       = sp_tens.digit;
    s4_d.d_unit       = sp_tens.rest[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_cmd_q <= cmd_i;
    end
    if (rdy2) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_thou_q <= sp_thou.digit;
      s2_rest_q <= sp_thou.rest[9:0];
    end
    if (rdy3) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_thou_q <= s2_thou_q;
      s3_hund_q <= sp_hund.digit;
      s3_rest_q <= sp_hund.rest[6:0];
    end
    if (rdy4) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = s4_q;

endmodule

@@ design/bcd_digit_display_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_digit_display_formatter
// Turns display commands into four code-B digit register writes each.
// ----------------------------------------------------------------------------
// channel   ports                     transfer
// command   start_i, busy_o, cmd_i    start_i high and busy_o low
// result    valid_o, res_o            valid_o high, one cycle per write
//
// A command needs four writes on the result port, one write per cycle; the
// single result port thus limits the sustained command rate. Each command
// passes through the 4 convert stages and then the write sequencer, and
// up to five commands are buffered in flight. busy_o rises only when every
// stage is full. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module bcd_digit_display_formatter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  bcdf_pkg::cmd_t cmd_i,
  output logic           valid_o,
  output bcdf_pkg::res_t res_o
);

  logic              conv_ready;
  logic              conv_valid;
  bcdf_pkg::digits_t conv_dig;
  logic              seq_free;
  logic              load;

  logic              seq_v_q;
  logic [1:0]        cnt_q;
  logic              grp_q;
  logic [7:0]        code_q [4];
  logic [7:0]        code_d [4];
  logic              blank3, blank2, blank1;

  bcdf_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i),
    .in_ready_o  (conv_ready),
    .cmd_i       (cmd_i),
    .out_valid_o (conv_valid),
    .out_ready_i (seq_free),
    .out_o       (conv_dig)
  );

  assign busy_o   = !conv_ready;
  assign seq_free = !seq_v_q || (cnt_q == 2'd3);
  assign load     = conv_valid && seq_free;

  // leading zero blanking for numbers, units never blanked there; LO/HI show L/H in units, CLEAR blanks all
  always_comb begin
    blank3 = (conv_dig.d_thou == 4'd0);
    blank2 = blank3 && (conv_dig.d_hund == 4'd0);
    blank1 = blank2 && (conv_dig.d_tens == 4'd0);
    if (conv_dig.opcode == bcdf_pkg::OP_NUMBER) begin
      code_d[0] = {conv_dig.point_bits[3], 3'd0, blank3 ? bcdf_pkg::CODE_BLANK : conv_dig.d_thou};
      code_d[1] = {conv_dig.point_bits[2], 3'd0, blank2 ? bcdf_pkg::CODE_BLANK : conv_dig.d_hund};
      code_d[2] = {conv_dig.point_bits[1], 3'd0, blank1 ? bcdf_pkg::CODE_BLANK : conv_dig.d_tens};
      code_d[3] = {conv_dig.point_bits[0], 3'd0, conv_dig.d_unit};
    end else begin
      code_d[0] = {4'd0, bcdf_pkg::CODE_BLANK};
      code_d[1] = {4'd0, bcdf_pkg::CODE_BLANK};
      code_d[2] = {4'd0, bcdf_pkg::CODE_BLANK};
      case (conv_dig.opcode)
        bcdf_pkg::OP_LO: code_d[3] = {4'd0, bcdf_pkg::CODE_L};
        bcdf_pkg::OP_HI: code_d[3] = {4'd0, bcdf_pkg::CODE_H};
        default:         code_d[3] = {4'd0, bcdf_pkg::CODE_BLANK};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_v_q <= 1'b0;
      cnt_q   <= 2'd0;
    end else if (load) begin
      seq_v_q <= 1'b1;
      cnt_q   <= 2'd0;
    end else if (seq_v_q) begin
      if (cnt_q == 2'd3) begin
        seq_v_q <= 1'b0;
      end
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= conv_dig.group_select;
      for (int i = 0; i < 4; i++) begin
        code_q[i] <= code_d[i];
      end
    end
  end

  assign valid_o              = seq_v_q;
  assign res_o.digit_register = {1'b0, grp_q, cnt_q} + 4'd1;
  assign res_o.digit_code     = code_q[cnt_q];
  assign res_o.last_write     = (cnt_q == 2'd3);

endmodule

@@ design/bcdf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdf_checker
// Port-level checks on the digit write stream of the display formatter.
// ----------------------------------------------------------------------------
module bcdf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy_o,
  input logic           valid_o,
  input bcdf_pkg::res_t res_o
);

  // writes of one command come in consecutive cycles
  a_burst_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.last_write |=> valid_o)
    else $error("write burst broken before units digit");

  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.last_write |=>
      res_o.digit_register == $past(res_o.digit_register) + 4'd1)
    else $error("digit address does not step by one");

  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.last_write |->
      (res_o.digit_register == 4'd4 || res_o.digit_register == 4'd8))
    else $error("units write on wrong address");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.digit_code[6:4] == 3'd0 && res_o.digit_code[3:0] != 4'd10 &&
      res_o.digit_code[3:0] != 4'd11 && res_o.digit_code[3:0] != 4'd14)
    else $error("illegal digit code");

  // busy only while a burst is still short of its units write
  a_busy_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> valid_o && !res_o.last_write)
    else $error("busy without a burst in progress");

endmodule

bind bcd_digit_display_formatter bcdf_checker u_bcdf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .res_o   (res_o)
);
